FILE: rtl/core/btlv_pkg.sv
// btlv_pkg: shared types and constants of the ber tlv header encoder
// no dependencies; used by every module of the encoder
package btlv_pkg;

  typedef logic [7:0] octet_t;

  localparam int MaxOctets = 6;
  localparam int CountW    = 3;

  localparam logic [2:0] KIND_INTEGER  = 3'd0;
  localparam logic [2:0] KIND_IA5      = 3'd1;
  localparam logic [2:0] KIND_OCTET    = 3'd2;
  localparam logic [2:0] KIND_SEQUENCE = 3'd3;
  localparam logic [2:0] KIND_SET      = 3'd4;
  localparam logic [2:0] KIND_CONTENT  = 3'd5;

  localparam octet_t TAG_INTEGER  = 8'h02;
  localparam octet_t TAG_IA5      = 8'h16;
  localparam octet_t TAG_OCTET    = 8'h04;
  localparam octet_t TAG_SEQUENCE = 8'h30;
  localparam octet_t TAG_SET      = 8'h31;
  localparam octet_t LEN_LONG     = 8'h80;

  // one classified word: octets in send order, index 0 first
  typedef struct packed {
    octet_t [MaxOctets-1:0] octets;
    logic   [CountW-1:0]    count;
  } desc_t;

endpackage

FILE: rtl/core/btlv_front.sv
// btlv_front: accepts input words and classifies them into octet descriptors
// depends on btlv_pkg
module btlv_front (
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           kind,
  input  logic signed [15:0]   int_value,
  input  logic [30:0]          content_length,
  input  logic [7:0]           data_byte,
  input  logic                 q_full,
  output logic                 wr_en,
  output btlv_pkg::desc_t      wr_desc
);

  logic [15:0]          raw;
  logic                 one;
  logic                 known;
  logic [2:0]           nlen;
  btlv_pkg::octet_t     tag;
  btlv_pkg::desc_t      hdr;

  assign raw  = int_value;
  assign one  = (raw <= 16'h007f) || (raw >= 16'hff80);
  assign full = q_full;

  always_comb begin
    if (content_length[30:24] != 7'd0) begin
      nlen = 3'd4;
    end else if (content_length[23:16] != 8'd0) begin
      nlen = 3'd3;
    end else if (content_length[15:8] != 8'd0) begin
      nlen = 3'd2;
    end else begin
      nlen = 3'd1;
    end
  end

  always_comb begin
    hdr = '0;
    hdr.octets[0] = tag;
    if (content_length < 31'd128) begin
      hdr.octets[1] = content_length[7:0];
      hdr.count = 3'd2;
    end else begin
      hdr.octets[1] = btlv_pkg::LEN_LONG | {5'd0, nlen};
      case (nlen)
        3'd1: begin
          hdr.octets[2] = content_length[7:0];
          hdr.count = 3'd3;
        end
        3'd2: begin
          hdr.octets[2] = content_length[15:8];
          hdr.octets[3] = content_length[7:0];
          hdr.count = 3'd4;
        end
        3'd3: begin
          hdr.octets[2] = content_length[23:16];
          hdr.octets[3] = content_length[15:8];
          hdr.octets[4] = content_length[7:0];
          hdr.count = 3'd5;
        end
        default: begin
          hdr.octets[2] = {1'b0, content_length[30:24]};
          hdr.octets[3] = content_length[23:16];
          hdr.octets[4] = content_length[15:8];
          hdr.octets[5] = content_length[7:0];
          hdr.count = 3'd6;
        end
      endcase
    end
  end

  always_comb begin
    tag     = btlv_pkg::TAG_IA5;
    known   = 1'b1;
    wr_desc = '0;
    case (kind)
      btlv_pkg::KIND_INTEGER: begin
        wr_desc.octets[0] = btlv_pkg::TAG_INTEGER;
        if (one) begin
          wr_desc.octets[1] = 8'd1;
          wr_desc.octets[2] = raw[7:0];
          wr_desc.count = 3'd3;
        end else begin
          wr_desc.octets[1] = 8'd2;
          wr_desc.octets[2] = raw[15:8];
          wr_desc.octets[3] = raw[7:0];
          wr_desc.count = 3'd4;
        end
      end
      btlv_pkg::KIND_IA5: begin
        tag = btlv_pkg::TAG_IA5;
        wr_desc = hdr;
      end
      btlv_pkg::KIND_OCTET: begin
        tag = btlv_pkg::TAG_OCTET;
        wr_desc = hdr;
      end
      btlv_pkg::KIND_SEQUENCE: begin
        tag = btlv_pkg::TAG_SEQUENCE;
        wr_desc = hdr;
      end
      btlv_pkg::KIND_SET: begin
        tag = btlv_pkg::TAG_SET;
        wr_desc = hdr;
      end
      btlv_pkg::KIND_CONTENT: begin
        wr_desc.octets[0] = data_byte;
        wr_desc.count = 3'd1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unused kinds are accepted and dropped
  assign wr_en = push && !q_full && known;

endmodule

FILE: rtl/core/btlv_queue.sv
// btlv_queue: short descriptor queue between front and back
// depends on btlv_pkg
module btlv_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  btlv_pkg::desc_t wr_desc,
  output logic            q_full,
  input  logic            rd_en,
  output logic            rd_valid,
  output btlv_pkg::desc_t rd_desc
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  btlv_pkg::desc_t  slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_wr;
  logic             do_rd;

  assign q_full   = (fill == CW'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_desc  = slots[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/btlv_back.sv
// btlv_back: serialises queued descriptors into octets behind an output register
// depends on btlv_pkg
module btlv_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_valid,
  input  btlv_pkg::desc_t  rd_desc,
  output logic             rd_en,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             last
);

  btlv_pkg::desc_t                 cur;
  logic                            cur_valid;
  logic [btlv_pkg::CountW-1:0]     idx;
  logic                            out_valid;

  logic                            slot_free;
  logic                            emit;
  btlv_pkg::desc_t                 src;
  logic [btlv_pkg::CountW-1:0]     src_idx;
  logic                            src_last;

  assign slot_free = !out_valid || pop;
  assign src       = cur_valid ? cur : rd_desc;
  assign src_idx   = cur_valid ? idx : '0;
  assign src_last  = (src_idx == src.count - 1'b1);
  assign emit      = slot_free && (cur_valid || rd_valid);
  // head leaves the queue when its first octet goes out
  assign rd_en     = emit && !cur_valid;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= src.octets[src_idx];
      last     <= src_last;
    end
    if (rd_en && !src_last) begin
      cur <= rd_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        cur_valid <= !src_last;
        idx       <= src_idx + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/ber_tlv_header_encoder.sv
// ber_tlv_header_encoder: top level of the asn.1 ber tlv encoder
// depends on btlv_pkg, btlv_front, btlv_queue, btlv_back
//
// Each input word (integer, ia5/octet/sequence/set header or content byte)
// becomes one to six BER octets on out_byte, with last set on its final
// octet. Content bytes stream at one word per cycle while pop frees the
// output register; an integer gives three or four octets, a header two
// to six, through the single output register of the back end. Input words
// are classified into a DEPTH-entry descriptor queue so that input keeps
// flowing while a long header drains. Kinds 6 and 7 are taken and dropped.
module ber_tlv_header_encoder #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          kind,
  input  logic signed [15:0]  int_value,
  input  logic [30:0]         content_length,
  input  logic [7:0]          data_byte,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte,
  output logic                last
);

  logic             q_full;
  logic             wr_en;
  btlv_pkg::desc_t  wr_desc;
  logic             rd_en;
  logic             rd_valid;
  btlv_pkg::desc_t  rd_desc;

  btlv_front u_front (
    .push           (push),
    .full           (full),
    .kind           (kind),
    .int_value      (int_value),
    .content_length (content_length),
    .data_byte      (data_byte),
    .q_full         (q_full),
    .wr_en          (wr_en),
    .wr_desc        (wr_desc)
  );

  btlv_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_desc  (wr_desc),
    .q_full   (q_full),
    .rd_en    (rd_en),
    .rd_valid (rd_valid),
    .rd_desc  (rd_desc)
  );

  btlv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (rd_valid),
    .rd_desc  (rd_desc),
    .rd_en    (rd_en),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last)
  );

endmodule

FILE: test/tb_ber_tlv_header_encoder.sv
// tb_ber_tlv_header_encoder: self-checking bench for the ber tlv header encoder
// depends on btlv_pkg and ber_tlv_header_encoder; predicts every octet and its last flag
`timescale 1ns / 1ps

module tb_ber_tlv_header_encoder;

  typedef struct packed {
    btlv_pkg::octet_t value;
    logic             last;
  } enc_octet_t;

  class octet_tracker;
    enc_octet_t expected_octets[$];
    int         errors = 0;

    task report_mismatch(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    function void put(btlv_pkg::octet_t v);
      enc_octet_t e;
      e.value = v;
      e.last  = 1'b0;
      expected_octets.push_back(e);
    endfunction

    // octets of one accepted word, last flag on the final one
    function void note_word(logic [2:0] k, logic signed [15:0] iv, logic [30:0] cl,
                            logic [7:0] db);
      int               n_before;
      int               count;
      btlv_pkg::octet_t tag;
      n_before = expected_octets.size();
      case (k)
        btlv_pkg::KIND_INTEGER: begin
          put(btlv_pkg::TAG_INTEGER);
          if (iv >= -128 && iv <= 127) begin
            put(8'd1);
            put(iv[7:0]);
          end else begin
            put(8'd2);
            put(iv[15:8]);
            put(iv[7:0]);
          end
        end
        btlv_pkg::KIND_IA5, btlv_pkg::KIND_OCTET, btlv_pkg::KIND_SEQUENCE,
        btlv_pkg::KIND_SET: begin
          case (k)
            btlv_pkg::KIND_IA5:      tag = btlv_pkg::TAG_IA5;
            btlv_pkg::KIND_OCTET:    tag = btlv_pkg::TAG_OCTET;
            btlv_pkg::KIND_SEQUENCE: tag = btlv_pkg::TAG_SEQUENCE;
            default:                 tag = btlv_pkg::TAG_SET;
          endcase
          put(tag);
          if (cl < 128) begin
            put(cl[7:0]);
          end else begin
            if (cl <= 31'h0000ff) count = 1;
            else if (cl <= 31'h00ffff) count = 2;
            else if (cl <= 31'hffffff) count = 3;
            else count = 4;
            put(btlv_pkg::LEN_LONG + btlv_pkg::octet_t'(count));
            for (int i = count - 1; i >= 0; i--) put(btlv_pkg::octet_t'(cl >> (8 * i)));
          end
        end
        btlv_pkg::KIND_CONTENT: put(db);
        default: ;
      endcase
      if (expected_octets.size() > n_before)
        expected_octets[expected_octets.size() - 1].last = 1'b1;
    endfunction

    task check_octet(btlv_pkg::octet_t got_byte, logic got_last);
      enc_octet_t e;
      if (expected_octets.size() == 0) begin
        report_mismatch($sformatf("unexpected octet %02h last %0b", got_byte, got_last));
      end else begin
        e = expected_octets.pop_front();
        if (got_byte !== e.value)
          report_mismatch($sformatf("out_byte %02h, want %02h", got_byte, e.value));
        if (got_last !== e.last)
          report_mismatch($sformatf("last %0b, want %0b (octet %02h)", got_last, e.last,
                                    e.value));
      end
    endtask

    function int pending();
      return expected_octets.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [2:0]         kind = btlv_pkg::KIND_CONTENT;
  logic signed [15:0] int_value = '0;
  logic [30:0]        content_length = '0;
  logic [7:0]         data_byte = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         out_byte;
  logic               last;

  octet_tracker book = new();
  int  send_idle = 0;
  int  recv_stall = 0;
  bit  long_hold = 1'b0;
  bit  hold_done = 1'b0;

  ber_tlv_header_encoder dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .kind(kind),
    .int_value(int_value),
    .content_length(content_length),
    .data_byte(data_byte),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task send_word(logic [2:0] k, logic signed [15:0] iv, logic [30:0] cl, logic [7:0] db);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    kind           <= k;
    int_value      <= iv;
    content_length <= cl;
    data_byte      <= db;
    push           <= 1'b1;
    do @(posedge clk); while (full);
    book.note_word(k, iv, cl, db);
  endtask

  task send_header(logic [2:0] k, logic [30:0] cl);
    send_word(k, 16'($urandom), cl, 8'($urandom));
  endtask

  task send_random_word();
    logic [2:0]         k;
    logic signed [15:0] iv;
    logic [30:0]        cl;
    logic [7:0]         db;
    int                 pick;
    iv   = 16'($urandom);
    cl   = 31'($urandom);
    db   = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) k = btlv_pkg::KIND_CONTENT;
    else if (pick < 60) k = btlv_pkg::KIND_INTEGER;
    else if (pick < 95) k = 3'($urandom_range(btlv_pkg::KIND_SET, btlv_pkg::KIND_IA5));
    else k = 3'($urandom_range(7, 6));
    if (k == btlv_pkg::KIND_INTEGER && $urandom_range(1) == 0)
      iv = 16'(int'($urandom_range(383)) - 192);
    case ($urandom_range(5))
      0: cl = 31'($urandom_range(127));
      1: cl = 31'($urandom_range(255, 128));
      2: cl = 31'($urandom_range(65535, 256));
      3: cl = 31'($urandom_range(24'hffffff, 65536));
      4: cl = 31'($urandom_range(31'h7fffffff, 31'h1000000));
      default: ;
    endcase
    send_word(k, iv, cl, db);
  endtask

  // result side: accepts, checks, stalls and takes one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) book.check_octet(out_byte, last);
      if (long_hold && !hold_done) begin
        pop <= 1'b0;
        hold_done = 1'b1;
        repeat (300) @(posedge clk);
      end
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words
    send_word(btlv_pkg::KIND_INTEGER, 16'sd0, 31'($urandom), 8'($urandom));
    send_word(btlv_pkg::KIND_INTEGER, 16'sd127, 31'($urandom), 8'($urandom));
    send_word(btlv_pkg::KIND_INTEGER, 16'sd128, 31'($urandom), 8'($urandom));
    send_word(btlv_pkg::KIND_INTEGER, -16'sd128, 31'($urandom), 8'($urandom));
    send_word(btlv_pkg::KIND_INTEGER, -16'sd129, 31'($urandom), 8'($urandom));
    send_word(btlv_pkg::KIND_INTEGER, 16'sd32767, 31'($urandom), 8'($urandom));
    send_word(btlv_pkg::KIND_INTEGER, -16'sd32768, 31'($urandom), 8'($urandom));
    send_word(btlv_pkg::KIND_INTEGER, -16'sd1, 31'($urandom), 8'($urandom));
    send_header(btlv_pkg::KIND_IA5, 31'd0);
    send_header(btlv_pkg::KIND_OCTET, 31'd127);
    send_header(btlv_pkg::KIND_SEQUENCE, 31'd128);
    send_header(btlv_pkg::KIND_SET, 31'd255);
    send_header(btlv_pkg::KIND_IA5, 31'd256);
    send_header(btlv_pkg::KIND_OCTET, 31'd65535);
    send_header(btlv_pkg::KIND_SEQUENCE, 31'd65536);
    send_header(btlv_pkg::KIND_SET, 31'hffffff);
    send_header(btlv_pkg::KIND_IA5, 31'h1000000);
    send_header(btlv_pkg::KIND_OCTET, 31'h7fffffff);
    send_header(btlv_pkg::KIND_SET, 31'h7fffffff);
    send_word(btlv_pkg::KIND_CONTENT, 16'($urandom), 31'($urandom), 8'h00);
    send_word(btlv_pkg::KIND_CONTENT, 16'($urandom), 31'($urandom), 8'hff);
    send_word(3'd6, 16'($urandom), 31'($urandom), 8'($urandom));
    send_word(3'd7, 16'($urandom), 31'($urandom), 8'($urandom));
    send_word(btlv_pkg::KIND_CONTENT, 16'($urandom), 31'($urandom), 8'h5a);

    // free flow, with one long hold-off on the result side
    long_hold = 1'b1;
    repeat (48) send_random_word();

    send_idle  = 69;
    recv_stall = 0;
    repeat (46) send_random_word();

    send_idle  = 0;
    recv_stall = 69;
    repeat (46) send_random_word();

    send_idle  = 32;
    recv_stall = 32;
    repeat (46) send_random_word();

    push <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/btlv_pkg.sv
rtl/core/btlv_front.sv
rtl/core/btlv_queue.sv
rtl/core/btlv_back.sv
rtl/core/ber_tlv_header_encoder.sv
test/tb_ber_tlv_header_encoder.sv
